[hdl/elf64_hdr_pkg.sv]
// ----------------------------------------------------------------------------
// ELF64 header parser package
// Shared constants, field layout table and result record for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package elf64_hdr_pkg;

  localparam int unsigned HDR_LEN    = 64;
  localparam int unsigned FIELD_BASE = 16;
  localparam int unsigned NUM_FIELDS = 13;

  localparam logic [6:0] HDR_LEN_B    = 7'(HDR_LEN);
  localparam logic [6:0] FIELD_BASE_B = 7'(FIELD_BASE);
  localparam logic [3:0] LAST_FIELD   = 4'(NUM_FIELDS - 1);

  // Magic bytes
  localparam logic [7:0] MAGIC0 = 8'h7F;
  localparam logic [7:0] MAGIC1 = 8'h45;
  localparam logic [7:0] MAGIC2 = 8'h4C;
  localparam logic [7:0] MAGIC3 = 8'h46;

  // Identification byte values
  localparam logic [7:0] CLASS_32  = 8'd1;
  localparam logic [7:0] CLASS_64  = 8'd2;
  localparam logic [7:0] DATA_LSB  = 8'd1;
  localparam logic [7:0] DATA_MSB  = 8'd2;
  localparam logic [7:0] EV_CURR   = 8'd1;
  localparam logic [7:0] ABI_SYSV  = 8'd0;

  // Identification byte offsets
  localparam logic [6:0] OFF_MAGIC_END = 7'd3;
  localparam logic [6:0] OFF_CLASS     = 7'd4;
  localparam logic [6:0] OFF_DATA      = 7'd5;
  localparam logic [6:0] OFF_VERSION   = 7'd6;
  localparam logic [6:0] OFF_ABI       = 7'd7;

  // Error codes
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_32BIT   = 3'd2;
  localparam logic [2:0] ERR_CLASS   = 3'd3;
  localparam logic [2:0] ERR_ENDIAN  = 3'd4;
  localparam logic [2:0] ERR_VERSION = 3'd5;
  localparam logic [2:0] ERR_ABI     = 3'd6;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [63:0] field_value;
    logic [2:0]  error_code;
    logic        last;
  } result_t;

  // First byte offset of each field; index NUM_FIELDS gives the header end
  function automatic logic [6:0] field_start(input logic [3:0] k);
    logic [6:0] s;
    unique case (k)
      4'd0:    s = 7'd16;
      4'd1:    s = 7'd18;
      4'd2:    s = 7'd20;
      4'd3:    s = 7'd24;
      4'd4:    s = 7'd32;
      4'd5:    s = 7'd40;
      4'd6:    s = 7'd48;
      4'd7:    s = 7'd52;
      4'd8:    s = 7'd54;
      4'd9:    s = 7'd56;
      4'd10:   s = 7'd58;
      4'd11:   s = 7'd60;
      4'd12:   s = 7'd62;
      default: s = HDR_LEN_B;
    endcase
    return s;
  endfunction

  // Field that owns a byte offset in the field area
  function automatic logic [3:0] field_of(input logic [6:0] off);
    logic [3:0] k;
    k = 4'd0;
    for (int i = 1; i < NUM_FIELDS; i++) begin
      if (off >= field_start(4'(i))) begin
        k = 4'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = MAGIC0;
      2'd1: m = MAGIC1;
      2'd2: m = MAGIC2;
      2'd3: m = MAGIC3;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/elf64_header_field_extractor.sv]
// ----------------------------------------------------------------------------
// ELF64 header field extractor
// Streams the 64-byte ELF64 file header in, one byte per transaction on the
// slave side; tuser bit 0 marks the first byte of a new header. After the
// identification checks (magic, 64-bit class, endianness, version, ABI) the
// thirteen header fields are emitted on the master side in header order,
// one transaction per field, assembled in the header's byte order. tlast
// marks the final field (section string index) or an error transaction.
// After an error or a complete header, bytes are dropped until a start mark.
// A result goes into the output register, or into the skid register while the
// output waits. Throughput: one byte per cycle while s_tready is high, set by
// the combinational parse step between the state and output registers.
// A two-entry output buffer (output register plus skid) keeps s_tready high
// while one result waits; s_tready falls only when both are full.
// Reset clears the parse state to offset 0 and empties the output buffer;
// bytes after reset parse from offset 0 even without a start mark.
// ----------------------------------------------------------------------------
`default_nettype none

module elf64_header_field_extractor
  import elf64_hdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] header_byte
  input  wire logic        s_tuser,   // [0] start_req
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [3:0] field_id, [67:4] field_value,
                                      // [70:68] error_code, [71] zero
  output logic             m_tlast    // last
);

  logic    in_accept;
  logic    out_pop;
  logic    res_valid;
  result_t res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;
  assign out_pop   = m_tvalid && m_tready;

  elf64_hdr_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .header_byte (s_tdata),
    .start_req   (s_tuser),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (!m_tvalid || out_pop) begin
        out_res  <= res;
        m_tvalid <= 1'b1;
      end else begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {1'b0, out_res.error_code, out_res.field_value, out_res.field_id};
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

[hdl/elf64_hdr_parse.sv]
// ----------------------------------------------------------------------------
// ELF64 header parser core
// Holds the parse state and works out the result of one header byte.
// ----------------------------------------------------------------------------
`default_nettype none

module elf64_hdr_parse
  import elf64_hdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  header_byte,
  input  wire logic        start_req,
  output logic             res_valid,
  output result_t          res
);

  logic [6:0]  byte_offset, byte_offset_next;
  logic [63:0] field_accumulator, field_accumulator_next;
  logic        magic_ok, magic_ok_next;
  logic        big_endian, big_endian_next;
  logic        halted, halted_next;

  logic [6:0]  off_cur;
  logic [63:0] acc_cur;
  logic        mok_cur;
  logic        be_cur;
  logic        halt_cur;
  logic [3:0]  k;
  logic [6:0]  k_start;
  logic [6:0]  k_end;
  logic [6:0]  pos;
  logic [63:0] acc_base;
  logic [63:0] acc_val;
  logic        mok_upd;

  // Apply a start request before the byte is looked at
  always_comb begin
    off_cur  = start_req ? 7'd0 : byte_offset;
    acc_cur  = start_req ? 64'd0 : field_accumulator;
    mok_cur  = start_req | magic_ok;
    be_cur   = start_req ? 1'b0 : big_endian;
    halt_cur = start_req ? 1'b0 : halted;
  end

  // Locate the byte inside its field and merge it into the accumulator
  always_comb begin
    k        = field_of(off_cur);
    k_start  = field_start(k);
    k_end    = field_start(k + 4'd1);
    pos      = off_cur - k_start;
    acc_base = (off_cur == k_start) ? 64'd0 : acc_cur;
    if (be_cur) begin
      acc_val = {acc_base[55:0], header_byte};
    end else begin
      acc_val = acc_base | ({56'd0, header_byte} << {pos[2:0], 3'b000});
    end
    mok_upd = mok_cur & (header_byte == magic_byte(off_cur[1:0]));
  end

  // Decide the next state and the result of this byte
  always_comb begin
    byte_offset_next       = off_cur;
    field_accumulator_next = acc_cur;
    magic_ok_next          = mok_cur;
    big_endian_next        = be_cur;
    halted_next            = halt_cur;
    res_valid              = 1'b0;
    res                    = '0;

    if (halt_cur || off_cur >= HDR_LEN_B) begin
      halted_next = 1'b1;
    end else begin
      byte_offset_next = off_cur + 7'd1;
      if (off_cur <= OFF_MAGIC_END) begin
        magic_ok_next = mok_upd;
        if (off_cur == OFF_MAGIC_END && !mok_upd) begin
          res_valid        = 1'b1;
          res.error_code   = ERR_MAGIC;
        end
      end else if (off_cur == OFF_CLASS) begin
        if (header_byte == CLASS_32) begin
          res_valid      = 1'b1;
          res.error_code = ERR_32BIT;
        end else if (header_byte != CLASS_64) begin
          res_valid      = 1'b1;
          res.error_code = ERR_CLASS;
        end
      end else if (off_cur == OFF_DATA) begin
        if (header_byte == DATA_LSB) begin
          big_endian_next = 1'b0;
        end else if (header_byte == DATA_MSB) begin
          big_endian_next = 1'b1;
        end else begin
          res_valid      = 1'b1;
          res.error_code = ERR_ENDIAN;
        end
      end else if (off_cur == OFF_VERSION) begin
        if (header_byte != EV_CURR) begin
          res_valid      = 1'b1;
          res.error_code = ERR_VERSION;
        end
      end else if (off_cur == OFF_ABI) begin
        if (header_byte != ABI_SYSV) begin
          res_valid      = 1'b1;
          res.error_code = ERR_ABI;
        end
      end else if (off_cur >= FIELD_BASE_B) begin
        // Field area: emit on the last byte of each field
        if (off_cur + 7'd1 == k_end) begin
          res_valid              = 1'b1;
          res.field_id           = k;
          res.field_value        = acc_val;
          res.error_code         = ERR_OK;
          res.last               = (k == LAST_FIELD);
          field_accumulator_next = 64'd0;
          if (k == LAST_FIELD) begin
            halted_next = 1'b1;
          end
        end else begin
          field_accumulator_next = acc_val;
        end
      end

      // Any check failure ends the header
      if (res_valid && res.error_code != ERR_OK) begin
        res.last    = 1'b1;
        halted_next = 1'b1;
      end
    end
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= 7'd0;
      field_accumulator <= 64'd0;
      magic_ok          <= 1'b1;
      big_endian        <= 1'b0;
      halted            <= 1'b0;
    end else if (accept) begin
      byte_offset       <= byte_offset_next;
      field_accumulator <= field_accumulator_next;
      magic_ok          <= magic_ok_next;
      big_endian        <= big_endian_next;
      halted            <= halted_next;
    end
  end

endmodule

`default_nettype wire
